/* design/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define NBCR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nbcr assertion failed");

// next-cycle implication, disabled while reset is low
`define NBCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nbcr assertion failed");

`endif

/* design/nbcr_pkg.sv */
package nbcr_pkg;

  localparam int unsigned PHASE_BITS = 24;
  localparam int unsigned STEP_W     = PHASE_BITS;
  localparam int unsigned GAIN_W     = 17;
  localparam int unsigned GAIN_FRAC  = 16;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned HIST_W     = 32;
  localparam int unsigned WINDOW_LEN = 4;
  localparam int unsigned SUM_W      = SAMPLE_W + $clog2(WINDOW_LEN);

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(419430);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(19661);

  typedef enum logic {
    REG_PHASE_STEP = 1'b0,
    REG_LOOP_GAIN  = 1'b1
  } reg_idx_e;

  // control into the phase accumulator
  typedef struct packed {
    logic advance;
    logic sample_pos;
    logic avg_pos;
  } loop_ctrl_t;

  // control into the bit slicer
  typedef struct packed {
    logic advance;
    logic wrap;
  } slice_ctrl_t;

endpackage

/* design/nbcr_regs.sv */
module nbcr_regs (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [nbcr_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [nbcr_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [nbcr_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                   pready,
  output logic [nbcr_pkg::STEP_W-1:0]            phase_step_o,
  output logic [nbcr_pkg::GAIN_W-1:0]            loop_gain_o
);
  import nbcr_pkg::*;

  logic [STEP_W-1:0] phase_step_q;
  logic [GAIN_W-1:0] loop_gain_q;
  logic              wr_en;
  reg_idx_e          reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[APB_ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= STEP_RESET;
      loop_gain_q  <= GAIN_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PHASE_STEP: phase_step_q <= pwdata[STEP_W-1:0];
        REG_LOOP_GAIN:  loop_gain_q  <= pwdata[GAIN_W-1:0];
        default:        phase_step_q <= phase_step_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PHASE_STEP: prdata = APB_DATA_W'(phase_step_q);
      REG_LOOP_GAIN:  prdata = APB_DATA_W'(loop_gain_q);
      default:        prdata = '0;
    endcase
  end

  assign phase_step_o = phase_step_q;
  assign loop_gain_o  = loop_gain_q;

endmodule

/* design/nbcr_phase.sv */
module nbcr_phase (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  nbcr_pkg::loop_ctrl_t         ctrl_i,
  input  logic [nbcr_pkg::STEP_W-1:0]  phase_step_i,
  input  logic [nbcr_pkg::GAIN_W-1:0]  loop_gain_i,
  output logic                         wrap_o
);
  import nbcr_pkg::*;

  localparam int unsigned DW = PHASE_BITS + 1;
  localparam int unsigned PW = DW + GAIN_W + 1;
  localparam int unsigned CW = PW - GAIN_FRAC;
  localparam int unsigned NW = PHASE_BITS + 4;
  localparam int unsigned TW = PHASE_BITS + 2;

  localparam logic signed [DW-1:0] HALF = {2'b01, {(PHASE_BITS - 1){1'b0}}};
  localparam logic signed [NW-1:0] FULL = {4'b0001, {PHASE_BITS{1'b0}}};

  logic [PHASE_BITS-1:0]    phase_q, phase_d;
  logic                     last_sign_q, last_sign_d;
  logic signed [DW-1:0]     delta;
  logic signed [PW-1:0]     prod;
  logic signed [CW-1:0]     corr;
  logic signed [NW-1:0]     pulled;
  logic [PHASE_BITS:0]      clamped;
  logic [PHASE_BITS:0]      base;
  logic [TW-1:0]            total;

  assign delta = $signed({1'b0, phase_q}) - HALF;
  assign prod  = delta * $signed({1'b0, loop_gain_i});
  // arithmetic shift floors toward minus infinity
  assign corr  = prod[PW-1:GAIN_FRAC];
  assign pulled = $signed({4'b0000, phase_q}) - $signed({{(NW - CW){corr[CW-1]}}, corr});

  always_comb begin
    priority if (pulled[NW-1]) begin
      clamped = '0;
    end else if (pulled > FULL) begin
      clamped = FULL[PHASE_BITS:0];
    end else begin
      clamped = pulled[PHASE_BITS:0];
    end
  end

  assign base   = (ctrl_i.sample_pos != last_sign_q) ? clamped : {1'b0, phase_q};
  assign total  = {1'b0, base} + {2'b00, phase_step_i};
  assign wrap_o = total[TW-1:PHASE_BITS] != 2'b00;

  // total stays below two periods, so dropping the top bits removes one period
  assign phase_d     = ctrl_i.advance ? total[PHASE_BITS-1:0] : phase_q;
  assign last_sign_d = !ctrl_i.advance ? last_sign_q :
                       wrap_o          ? ctrl_i.avg_pos : ctrl_i.sample_pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      last_sign_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      last_sign_q <= last_sign_d;
    end
  end

endmodule

/* design/nbcr_slicer.sv */
module nbcr_slicer (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  nbcr_pkg::slice_ctrl_t                 ctrl_i,
  input  logic signed [nbcr_pkg::SAMPLE_W-1:0]  sample_i,
  output logic                                  avg_pos_o,
  output logic                                  bit_value_o,
  output logic [nbcr_pkg::HIST_W-1:0]           history_o
);
  import nbcr_pkg::*;

  localparam logic signed [SUM_W-1:0] THRESH = SUM_W'(WINDOW_LEN);

  // previous samples, newest first
  logic signed [SAMPLE_W-1:0] window_q [WINDOW_LEN-1];
  logic signed [SUM_W-1:0]    sum;
  logic [HIST_W-1:0]          hist_q;

  always_comb begin
    sum = SUM_W'(sample_i);
    for (int k = 0; k < WINDOW_LEN - 1; k++) begin
      sum = sum + SUM_W'(window_q[k]);
    end
  end

  assign avg_pos_o   = sum >= THRESH;
  assign bit_value_o = !avg_pos_o;
  assign history_o   = {hist_q[HIST_W-2:0], bit_value_o};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WINDOW_LEN - 1; k++) begin
        window_q[k] <= '0;
      end
      hist_q <= '0;
    end else if (ctrl_i.advance) begin
      window_q[0] <= sample_i;
      for (int k = 1; k < WINDOW_LEN - 1; k++) begin
        window_q[k] <= window_q[k-1];
      end
      if (ctrl_i.wrap) begin
        hist_q <= history_o;
      end
    end
  end

endmodule

/* design/nrz_bit_clock_recovery_unit.sv */
// nrz bit clock recovery
// input stream: one signed 16-bit discriminator sample per request on s_axis
// output stream: one decided bit and the 32-bit history of decided bits, sent
//   only on samples where the bit-period phase wraps (about one per
//   sample_rate / baud samples)
// apb port: register 0 (address 0) phase step, register 1 (address 4) loop
//   gain in q1.16; writes are meant for an idle block
// processing: a sample in the input register enters the phase loop once the
//   result register is free; when the phase wraps, its result enters the output
//   register, which drives m_axis_tvalid
// throughput: one sample per cycle while no result stalls, limited by the phase
//   loop (gain multiply, clamp and step add on the stored phase)
// stalls: the input register waits while the output register holds a result
//   not yet taken; s_axis_tready falls only then
// reset: phase, sign, sample window and history clear; registers return to
//   1200 baud at 48 kHz and a gain of 0.3
module nrz_bit_clock_recovery_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [nbcr_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // [15:0] sample
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [nbcr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // [0] bit_value, [32:1] bit_history
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [nbcr_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [nbcr_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [nbcr_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import nbcr_pkg::*;

  logic [STEP_W-1:0]          phase_step;
  logic [GAIN_W-1:0]          loop_gain;
  logic                       in_valid_q, in_valid_d;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       out_valid_q, out_valid_d;
  logic                       out_bit_q;
  logic [HIST_W-1:0]          out_hist_q;
  logic                       out_free;
  logic                       advance;
  logic                       wrap;
  logic                       avg_pos;
  logic                       bit_value;
  logic [HIST_W-1:0]          history;
  loop_ctrl_t                 loop_ctrl;
  slice_ctrl_t                slice_ctrl;

  nbcr_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .phase_step_o (phase_step),
    .loop_gain_o  (loop_gain)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  assign loop_ctrl.advance    = advance;
  assign loop_ctrl.sample_pos = !sample_q[SAMPLE_W-1] && (sample_q != '0);
  assign loop_ctrl.avg_pos    = avg_pos;

  assign slice_ctrl.advance = advance;
  assign slice_ctrl.wrap    = wrap;

  nbcr_phase u_phase (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (loop_ctrl),
    .phase_step_i (phase_step),
    .loop_gain_i  (loop_gain),
    .wrap_o       (wrap)
  );

  nbcr_slicer u_slicer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (slice_ctrl),
    .sample_i    (sample_q),
    .avg_pos_o   (avg_pos),
    .bit_value_o (bit_value),
    .history_o   (history)
  );

  // input register
  assign in_valid_d = s_axis_tready ? s_axis_tvalid : in_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      sample_q <= s_axis_tdata[SAMPLE_W-1:0];
    end
  end

  // result register
  always_comb begin
    priority if (advance && wrap) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && wrap) begin
      out_bit_q  <= bit_value;
      out_hist_q <= history;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - HIST_W - 1){1'b0}}, out_hist_q, out_bit_q};

endmodule

/* design/nbcr_checker.sv */
`include "assert_macros.svh"

module nbcr_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [nbcr_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
  import nbcr_pkg::*;

  // a stalled result keeps its payload
  `NBCR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

  // the decided bit is the newest history bit
  `NBCR_ASSERT_IMPL(a_bit_in_hist, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[0] == m_axis_tdata[1])

  // input only waits behind a stalled result
  `NBCR_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

  // padding above the history stays zero
  `NBCR_ASSERT_IMPL(a_pad_zero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[OUT_DATA_W-1:HIST_W+1] == '0)

endmodule

bind nrz_bit_clock_recovery_unit nbcr_checker u_nbcr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
